/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the bounded deque.
// No dependencies; taken in by `include where checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define BDI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bdi check failed");

// Same, with a caller-supplied message.
`define BDI_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* rtl/core/bdi_pkg.sv */
// Package for the bounded deque: sizes, field widths, codes and the
// command struct that the control hands to the row of cells. No dependencies.
`default_nettype none

package bdi_pkg;

   localparam int DEPTH       = 256;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   localparam int ELEM_WIDTH  = 32;

   localparam int MODE_WIDTH   = 3;
   localparam int WORD_WIDTH   = 32;
   localparam int INDEX_WIDTH  = 8;
   localparam int STATUS_WIDTH = 2;
   localparam int ECOUNT_WIDTH = 9;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CAP_WIDTH      = 9;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(200);
   localparam logic [0:0] REG_CAPACITY_LIMIT = 1'b0;

   localparam logic [MODE_WIDTH-1:0] MODE_PUSH_HEAD = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_PUSH_TAIL = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_HEAD  = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_TAIL  = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_READ      = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_HEAD,
      CELL_SHIFT_DOWN,
      CELL_WRITE_TAIL,
      CELL_LOAD_CARRY,
      CELL_SHIFT_CARRY
   } cell_op_type;

   typedef struct packed {
      cell_op_type                 op;
      logic [ELEM_WIDTH-1:0]       word;
      logic [ADDR_BITS-1:0]        tail_slot;
   } cell_cmd_type;

   typedef struct packed {
      logic                        busy;
      logic [COUNT_BITS-1:0]       count;
   } ctrl_status_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SHIFT
   } ctrl_state_type;

endpackage

`default_nettype wire

/* rtl/core/bdi_chan_if.sv */
// Valid/ready channel interfaces for the deque's request and response words.
// Depends on bdi_pkg for the field widths.
`default_nettype none

interface bdi_req_if;
   logic                                valid;
   logic                                ready;
   logic [bdi_pkg::MODE_WIDTH-1:0]      mode;
   logic [bdi_pkg::WORD_WIDTH-1:0]      element_word;
   logic [bdi_pkg::INDEX_WIDTH-1:0]     read_index;

   modport source (output valid, mode, element_word, read_index, input ready);
   modport sink   (input valid, mode, element_word, read_index, output ready);
endinterface

interface bdi_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bdi_pkg::WORD_WIDTH-1:0]      read_word;
   logic                                found;
   logic [bdi_pkg::STATUS_WIDTH-1:0]    status;
   logic [bdi_pkg::ECOUNT_WIDTH-1:0]    entry_count;

   modport source (output valid, read_word, found, status, entry_count, input ready);
   modport sink   (input valid, read_word, found, status, entry_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/bdi_cell.sv */
// One slot of the deque row: an element register and a carry register that
// moves read data towards the head. Depends on bdi_pkg.
`default_nettype none

module bdi_cell (
   input  wire                            clock,
   input  bdi_pkg::cell_cmd_type          cmd,
   input  wire [bdi_pkg::ADDR_BITS-1:0]   cell_pos,
   input  wire [bdi_pkg::ELEM_WIDTH-1:0]  left_entry,
   input  wire [bdi_pkg::ELEM_WIDTH-1:0]  right_entry,
   input  wire [bdi_pkg::ELEM_WIDTH-1:0]  right_carry,
   output logic [bdi_pkg::ELEM_WIDTH-1:0] entry,
   output logic [bdi_pkg::ELEM_WIDTH-1:0] carry
);
   import bdi_pkg::*;

   logic [ELEM_WIDTH-1:0] entry_ff, entry_in;
   logic [ELEM_WIDTH-1:0] carry_ff, carry_in;

   always_comb begin
      entry_in = entry_ff;
      carry_in = carry_ff;
      case (cmd.op)
         CELL_PUSH_HEAD:   entry_in = left_entry;
         CELL_SHIFT_DOWN:  entry_in = right_entry;
         CELL_WRITE_TAIL: begin
            if (cmd.tail_slot == cell_pos) begin
               entry_in = cmd.word;
            end
         end
         CELL_LOAD_CARRY:  carry_in = entry_ff;
         CELL_SHIFT_CARRY: carry_in = right_carry;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      carry_ff <= carry_in;
   end

   assign entry = entry_ff;
   assign carry = carry_ff;

endmodule

`default_nettype wire

/* rtl/core/bdi_ctrl.sv */
// Control of the deque: request decode, count, capacity register, read
// sequencing over the cell row and the response register. Depends on bdi_pkg
// and the channel interfaces.
`default_nettype none

module bdi_ctrl (
   input  wire                                 clock,
   input  wire                                 reset,
   bdi_req_if.sink                             req_ch,
   bdi_rsp_if.source                           rsp_ch,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire [bdi_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire [bdi_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [bdi_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   input  wire [bdi_pkg::ELEM_WIDTH-1:0]       head_carry,
   output bdi_pkg::cell_cmd_type               cell_cmd,
   output bdi_pkg::ctrl_status_type            ctrl_status
);
   import bdi_pkg::*;

   localparam logic [COUNT_BITS-1:0] DEPTH_COUNT = COUNT_BITS'(DEPTH);

   ctrl_state_type          state_ff, state_in;
   logic [INDEX_WIDTH-1:0]  steps_ff, steps_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [CAP_WIDTH-1:0]    cap_ff, cap_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WORD_WIDTH-1:0]   rsp_word_ff, rsp_word_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   logic                    accept;
   logic                    reg_hit;
   logic [COUNT_BITS-1:0]   limit;
   logic                    is_full;
   logic                    is_empty;

   assign reg_hit  = (csr_paddr[CSR_ADDR_WIDTH-1] == REG_CAPACITY_LIMIT);
   assign limit    = ({1'b0, cap_ff[CAP_WIDTH-2:0]} > DEPTH_COUNT || cap_ff[CAP_WIDTH-1])
                     ? DEPTH_COUNT : COUNT_BITS'(cap_ff);
   assign is_full  = (count_ff >= limit);
   assign is_empty = (count_ff == '0);

   // Take a new word only when idle and the response slot is free or leaving.
   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      cap_in = cap_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         cap_in = csr_pwdata[CAP_WIDTH-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      steps_in      = steps_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_word_in   = rsp_word_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      cell_cmd.op        = CELL_HOLD;
      cell_cmd.word      = req_ch.element_word[ELEM_WIDTH-1:0];
      cell_cmd.tail_slot = count_ff[ADDR_BITS-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = '0;
               rsp_found_in  = 1'b0;
               rsp_status_in = STATUS_DONE;
               unique case (req_ch.mode) inside
                  MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cell_cmd.op = (req_ch.mode == MODE_PUSH_HEAD)
                                      ? CELL_PUSH_HEAD : CELL_WRITE_TAIL;
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  MODE_POP_HEAD, MODE_POP_TAIL: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        if (req_ch.mode == MODE_POP_HEAD) begin
                           cell_cmd.op = CELL_SHIFT_DOWN;
                        end
                        count_in = count_ff - 1'b1;
                     end
                  end
                  MODE_READ: begin
                     if (COUNT_BITS'(req_ch.read_index) < count_ff) begin
                        // Snapshot the row into the carries, then walk it down.
                        cell_cmd.op  = CELL_LOAD_CARRY;
                        steps_in     = req_ch.read_index;
                        state_in     = ST_SHIFT;
                        rsp_valid_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SHIFT: begin
            if (steps_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = WORD_WIDTH'(head_carry);
               rsp_found_in  = 1'b1;
               rsp_status_in = STATUS_DONE;
               state_in      = ST_IDLE;
            end else begin
               cell_cmd.op = CELL_SHIFT_CARRY;
               steps_in    = steps_ff - 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         steps_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         steps_ff     <= steps_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff   <= rsp_word_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   // The response count is taken from the next count value, so it shows the count after the item.
   logic [COUNT_BITS-1:0] rsp_count_ff;
   always_ff @(posedge clock) begin
      if (rsp_valid_in && !(rsp_valid_ff && !rsp_ch.ready)) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_word   = rsp_word_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_count = ECOUNT_WIDTH'(rsp_count_ff);

   assign csr_prdata = reg_hit ? CSR_DATA_WIDTH'(cap_ff) : '0;
   assign csr_pready = 1'b1;

   assign ctrl_status.busy  = (state_ff == ST_SHIFT);
   assign ctrl_status.count = count_ff;

endmodule

`default_nettype wire

/* rtl/core/bounded_deque_indexed.sv */
// Bounded deque of 32-bit words held in a row of 256 cells, head at cell 0.
// Inserts, removals and out-of-range reads are taken while idle and their
// result appears in the response register the cycle after. A read at index k
// holds the block while the row is copied into per-cell carry registers and
// shifted one cell a cycle towards the head, k times, so the wait grows with
// the index. A new word is taken whenever the block is not walking a read and
// the response register is empty or being taken.
// No clearing pass after reset; the capacity register answers at addresses 0 to 3.
`default_nettype none

`include "assert_macros.svh"

module bounded_deque_indexed (
   input  wire                                 clock,
   input  wire                                 reset,
   bdi_req_if.sink                             req_ch,
   bdi_rsp_if.source                           rsp_ch,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire [bdi_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire [bdi_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [bdi_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import bdi_pkg::*;

   cell_cmd_type          cell_cmd;
   ctrl_status_type       ctrl_status;
   logic [ELEM_WIDTH-1:0] entry_bus [DEPTH];
   logic [ELEM_WIDTH-1:0] carry_bus [DEPTH];

   bdi_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .head_carry  (carry_bus[0]),
      .cell_cmd    (cell_cmd),
      .ctrl_status (ctrl_status)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left_entry;
      logic [ELEM_WIDTH-1:0] right_entry;
      logic [ELEM_WIDTH-1:0] right_carry;

      if (i == 0) begin : g_head
         assign left_entry = cell_cmd.word;
      end else begin : g_mid
         assign left_entry = entry_bus[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign right_entry = '0;
         assign right_carry = '0;
      end else begin : g_inner
         assign right_entry = entry_bus[i+1];
         assign right_carry = carry_bus[i+1];
      end

      bdi_cell u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .cell_pos    (ADDR_BITS'(i)),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .right_carry (right_carry),
         .entry       (entry_bus[i]),
         .carry       (carry_bus[i])
      );
   end

   `BDI_ASSERT(a_count_bounded, clock, reset, ctrl_status.count <= COUNT_BITS'(DEPTH))
   `BDI_ASSERT_MSG(a_no_overwrite, clock, reset,
      (req_ch.valid && req_ch.ready) |-> (!rsp_ch.valid || rsp_ch.ready),
      "word taken while response slot is blocked")
   `BDI_ASSERT_MSG(a_walk_only_busy, clock, reset,
      (cell_cmd.op == CELL_SHIFT_CARRY) |-> ctrl_status.busy,
      "carry chain shifted outside a read")
   `BDI_ASSERT_MSG(a_found_done, clock, reset,
      (rsp_ch.valid && rsp_ch.found) |-> (rsp_ch.status == STATUS_DONE),
      "found response with refusal status")

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking bench for bounded_deque_indexed: request words go in through
// the valid/ready channels and capacity changes through the APB port.
// Depends on bdi_pkg, the channel interfaces in bdi_chan_if and the deque RTL.

module tb;
   import bdi_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = DEPTH + 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int MAX_SHOWN       = 10;

   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_LAST  = 3'd7;

   localparam logic [CSR_ADDR_WIDTH-1:0] CAPACITY_ADDR =
      CSR_ADDR_WIDTH'(4 * REG_CAPACITY_LIMIT);

   localparam int CAP_NONE       = 0;
   localparam int CAP_ONE        = 1;
   localparam int CAP_TINY       = 3;
   localparam int CAP_MID        = 37;
   localparam int CAP_FULL_DEPTH = 256;
   localparam int CAP_FIELD_MAX  = 511;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]  mode;
      logic [WORD_WIDTH-1:0]  element_word;
      logic [INDEX_WIDTH-1:0] read_index;
   } deque_request_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0]   read_word;
      logic                    found;
      logic [STATUS_WIDTH-1:0] status;
      logic [ECOUNT_WIDTH-1:0] entry_count;
   } deque_result_type;

   // Mirror of the list as a queue, head at index 0.
   class deque_scoreboard_type;
      logic [ELEM_WIDTH-1:0] held_words[$];
      logic [CAP_WIDTH-1:0]  capacity;
      deque_result_type      due_results[$];
      int                    failures;
      int                    checked;

      function new();
         capacity = CAP_RESET;
         failures = 0;
         checked  = 0;
      endfunction

      function void set_capacity(logic [CAP_WIDTH-1:0] value);
         capacity = value;
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction

      function int entries();
         return held_words.size();
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= MAX_SHOWN) $display("%s", msg);
      endfunction

      function void note_request(deque_request_type req);
         deque_result_type res;
         int               limit;
         res   = '0;
         limit = (capacity > DEPTH) ? DEPTH : capacity;
         case (req.mode) inside
            MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
               if (held_words.size() >= limit)
                  res.status = STATUS_FULL;
               else if (req.mode == MODE_PUSH_HEAD)
                  held_words.push_front(req.element_word[ELEM_WIDTH-1:0]);
               else
                  held_words.push_back(req.element_word[ELEM_WIDTH-1:0]);
            end
            MODE_POP_HEAD, MODE_POP_TAIL: begin
               if (held_words.size() == 0)
                  res.status = STATUS_EMPTY;
               else if (req.mode == MODE_POP_HEAD)
                  void'(held_words.pop_front());
               else
                  void'(held_words.pop_back());
            end
            MODE_READ: begin
               if (req.read_index < held_words.size()) begin
                  res.read_word = WORD_WIDTH'(held_words[req.read_index]);
                  res.found     = 1'b1;
               end
            end
            default: ;
         endcase
         res.status      = (res.status == STATUS_FULL) ? STATUS_FULL : res.status;
         res.entry_count = ECOUNT_WIDTH'(held_words.size());
         due_results.push_back(res);
      endfunction

      function void check_response(deque_result_type got);
         deque_result_type want;
         checked++;
         if (due_results.size() == 0) begin
            flag($sformatf("response %0d with nothing expected: word %h found %b status %0d count %0d",
                           checked, got.read_word, got.found, got.status, got.entry_count));
            return;
         end
         want = due_results.pop_front();
         if (got.read_word !== want.read_word || got.found !== want.found ||
             got.status !== want.status || got.entry_count !== want.entry_count)
            flag($sformatf({"response %0d: expected word %h found %b status %0d count %0d,",
                            " got word %h found %b status %0d count %0d"},
                           checked, want.read_word, want.found, want.status,
                           want.entry_count, got.read_word, got.found, got.status,
                           got.entry_count));
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   bdi_req_if req_ch();
   bdi_rsp_if rsp_ch();

   deque_scoreboard_type board = new();
   int                   sink_hold_cycles = 0;
   bit                   quiet_tail = 1'b0;

   bounded_deque_indexed uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // Result side: random stalls, one long hold-off on request, none at the tail.
   initial begin : response_sink
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (sink_hold_cycles != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_response({rsp_ch.read_word, rsp_ch.found, rsp_ch.status,
                               rsp_ch.entry_count});
   end

   function automatic deque_request_type make_item(input logic [MODE_WIDTH-1:0] mode,
                                                   input logic [WORD_WIDTH-1:0] word,
                                                   input int unsigned idx);
      deque_request_type item;
      item.mode         = mode;
      item.element_word = word;
      item.read_index   = INDEX_WIDTH'(idx);
      return item;
   endfunction

   function automatic deque_request_type pick_request(input int ins_pct, input int rem_pct);
      deque_request_type item;
      int                roll;
      int                held;
      int                sel;
      item.element_word = $urandom();
      item.read_index   = INDEX_WIDTH'($urandom());
      held = board.entries();
      roll = $urandom_range(0, 99);
      sel  = $urandom_range(0, 9);
      if (roll < ins_pct) begin
         item.mode = $urandom_range(0, 1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD;
      end else if (roll < ins_pct + rem_pct) begin
         item.mode = $urandom_range(0, 1) ? MODE_POP_TAIL : MODE_POP_HEAD;
      end else if ($urandom_range(0, 7) == 0) begin
         item.mode = MODE_WIDTH'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      end else begin
         // keep most reads near the head: a deep read stalls the block for long
         item.mode = MODE_READ;
         if (held > 0 && sel < 5)
            item.read_index = INDEX_WIDTH'($urandom_range(0, (held > 8) ? 7 : held - 1));
         else if (held > 0 && sel < 8)
            item.read_index = INDEX_WIDTH'($urandom_range(0, held - 1));
      end
      return item;
   endfunction

   task automatic send_word(input deque_request_type item);
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= item.mode;
      req_ch.element_word <= item.element_word;
      req_ch.read_index   <= item.read_index;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(item);
   endtask

   // Gap after a word; every third stretch of 16 words runs back to back.
   task automatic maybe_pause(input int serial);
      if (!quiet_tail && (serial % 48) < 32 && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic send_list(input deque_request_type items[$]);
      foreach (items[i]) begin
         send_word(items[i]);
         maybe_pause(i);
      end
   endtask

   task automatic csr_write(input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_capacity(value[CAP_WIDTH-1:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [CAP_WIDTH-1:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CAPACITY_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_WIDTH'(want))
         board.flag($sformatf("capacity read back %h, expected %h", csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drain every outstanding result before touching the register.
   task automatic set_capacity_idle(input int cap);
      logic [CSR_DATA_WIDTH-1:0] value;
      req_ch.valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      value = $urandom_range(0, 1) ? $urandom() : '0;
      value[CAP_WIDTH-1:0] = CAP_WIDTH'(cap);
      csr_write(value);
      csr_read_check(CAP_WIDTH'(cap));
   endtask

   task automatic run_phase(input int cap, input int items, input int ins_pct,
                            input int rem_pct, input int hold);
      set_capacity_idle(cap);
      sink_hold_cycles = hold;
      for (int n = 0; n < items; n++) begin
         send_word(pick_request(ins_pct, rem_pct));
         maybe_pause(n);
      end
   endtask

   initial begin : stimulus
      deque_request_type opening[$];
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.mode         <= MODE_PUSH_HEAD;
      req_ch.element_word <= '0;
      req_ch.read_index   <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      csr_read_check(CAP_RESET);

      // empty list first, then four words read from both ends and past the end
      opening.push_back(make_item(MODE_POP_HEAD, $urandom(), $urandom()));
      opening.push_back(make_item(MODE_POP_TAIL, $urandom(), $urandom()));
      opening.push_back(make_item(MODE_READ, $urandom(), '0));
      opening.push_back(make_item(MODE_READ, $urandom(), '1));
      opening.push_back(make_item(MODE_PUSH_HEAD, '0, $urandom()));
      opening.push_back(make_item(MODE_PUSH_TAIL, '1, $urandom()));
      opening.push_back(make_item(MODE_PUSH_HEAD, 32'hA5A5_A5A5, $urandom()));
      opening.push_back(make_item(MODE_PUSH_TAIL, 32'h5A5A_5A5A, $urandom()));
      for (int i = 0; i < 5; i++)
         opening.push_back(make_item(MODE_READ, $urandom(), i));
      opening.push_back(make_item(MODE_READ, $urandom(), '1));
      opening.push_back(make_item(MODE_SPARE_FIRST, '1, '1));
      opening.push_back(make_item(MODE_SPARE_LAST, '0, '0));
      opening.push_back(make_item(MODE_POP_HEAD, $urandom(), $urandom()));
      opening.push_back(make_item(MODE_POP_TAIL, $urandom(), $urandom()));
      opening.push_back(make_item(MODE_READ, $urandom(), 1));
      send_list(opening);

      // capacity below the count: inserts refused, the rest still served
      set_capacity_idle(CAP_ONE);
      opening.delete();
      opening.push_back(make_item(MODE_PUSH_TAIL, $urandom(), $urandom()));
      opening.push_back(make_item(MODE_READ, $urandom(), 1));
      opening.push_back(make_item(MODE_POP_HEAD, $urandom(), $urandom()));
      opening.push_back(make_item(MODE_PUSH_HEAD, $urandom(), $urandom()));
      send_list(opening);

      set_capacity_idle(CAP_NONE);
      opening.delete();
      opening.push_back(make_item(MODE_POP_TAIL, $urandom(), $urandom()));
      opening.push_back(make_item(MODE_PUSH_TAIL, $urandom(), $urandom()));
      send_list(opening);

      // fill to the store depth while the result side holds off, then refuse,
      // shrink and drain, then small capacities
      run_phase(CAP_FULL_DEPTH, 270, 98, 1, HOLD_OFF_CYCLES);
      run_phase(CAP_FIELD_MAX, 20, 70, 10, 0);
      run_phase(CAP_TINY, 265, 2, 96, 0);
      run_phase(int'(CAP_RESET), 20, 40, 40, 0);
      run_phase(CAP_ONE, 15, 50, 30, 0);
      run_phase(CAP_NONE, 10, 60, 20, 0);
      run_phase(CAP_MID, 20, 60, 25, 0);
      quiet_tail = 1'b1;
      run_phase(CAP_FULL_DEPTH, 20, 45, 35, 0);

      req_ch.valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.outstanding() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
